/* src/ped_pkg.sv */
`timescale 1ns / 1ps

package ped_pkg;

    // Character codes used by the escape scanner.
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [3:0] HEX_TEN    = 4'd10;

    // Default depth of the command queue between the front and back ends.
    localparam int QUEUE_DEPTH_DEF = 2;

    // One command from the front end: up to three output bytes and the
    // last flag, which belongs to the final byte of the command.
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic       last;
    } t_cmd;

    // Decoded uppercase hex digit: valid flag and the four-bit value.
    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex       r;
        logic [7:0] d;
        r = '0;
        d = 8'd0;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            d       = c - CH_ZERO;
            r.valid = 1'b1;
            r.value = d[3:0];
        end else if (c inside {[CH_UPPER_A:CH_UPPER_F]}) begin
            d       = c - CH_UPPER_A;
            r.valid = 1'b1;
            r.value = HEX_TEN + d[3:0];
        end
        return r;
    endfunction

endpackage

/* src/ped_if.sv */
`timescale 1ns / 1ps

// Encoded input channel.
interface ped_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// Decoded output channel.
interface ped_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output out_last, input ready);
    modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

/* src/ped_front.sv */
`timescale 1ns / 1ps

module ped_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ped_in_if.sink       i_in,
    output logic         o_cmd_valid,
    input  logic         i_cmd_ready,
    output ped_pkg::t_cmd o_cmd
);
    import ped_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PCT,
        PH_DIGIT
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic       w_xfer;
    logic       w_emit;
    t_hex       w_hi, w_lo;

    // A byte is taken whenever the queue has room for the command it may cause.
    assign i_in.ready  = i_cmd_ready;
    assign w_xfer      = i_in.valid && i_cmd_ready;
    assign o_cmd_valid = w_xfer && w_emit;

    assign w_hi = hex_decode(r_held);
    assign w_lo = hex_decode(i_in.in_byte);

    // Classify the incoming byte against the escape state.
    always_comb begin
        n_phase    = r_phase;
        n_held     = r_held;
        w_emit     = 1'b0;
        o_cmd      = '0;
        o_cmd.last = i_in.in_last;
        case (r_phase)
            PH_PCT: begin
                if (i_in.in_last) begin
                    w_emit   = 1'b1;
                    o_cmd.count = 2'd2;
                    o_cmd.b0 = CH_PERCENT;
                    o_cmd.b1 = i_in.in_byte;
                    n_phase  = PH_IDLE;
                end else begin
                    n_held  = i_in.in_byte;
                    n_phase = PH_DIGIT;
                end
            end
            PH_DIGIT: begin
                w_emit  = 1'b1;
                n_phase = PH_IDLE;
                if (w_hi.valid && w_lo.valid) begin
                    o_cmd.count = 2'd1;
                    o_cmd.b0    = {w_hi.value, w_lo.value};
                end else begin
                    o_cmd.count = 2'd3;
                    o_cmd.b0    = CH_PERCENT;
                    o_cmd.b1    = r_held;
                    o_cmd.b2    = i_in.in_byte;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (i_in.in_byte == CH_PERCENT && !i_in.in_last) begin
                    n_phase = PH_PCT;
                end else begin
                    w_emit      = 1'b1;
                    o_cmd.count = 2'd1;
                    o_cmd.b0    = i_in.in_byte;
                end
            end
        endcase
    end

    // Escape state advances only on a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= 8'd0;
        end else if (w_xfer) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

/* src/ped_queue.sv */
`timescale 1ns / 1ps

module ped_queue #(
    parameter int DEPTH = ped_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push_valid,
    output logic          o_push_ready,
    input  ped_pkg::t_cmd i_push_cmd,
    output logic          o_pop_valid,
    input  logic          i_pop_ready,
    output ped_pkg::t_cmd o_pop_cmd
);
    import ped_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_push_ready = (r_count != CNT_FULL);
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_cmd    = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Storage write.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* src/ped_back.sv */
`timescale 1ns / 1ps

module ped_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    output logic          o_cmd_ready,
    input  ped_pkg::t_cmd i_cmd,
    ped_out_if.source     o_out
);
    import ped_pkg::*;

    logic       r_busy;
    t_cmd       r_cmd;
    logic [1:0] r_idx;
    logic       w_at_end;
    logic       w_out_xfer;

    assign w_at_end    = (r_idx == r_cmd.count - 2'd1);
    assign w_out_xfer  = o_out.valid && o_out.ready;
    assign o_cmd_ready = !r_busy || (w_out_xfer && w_at_end);

    // Output byte comes straight from the held command.
    assign o_out.valid    = r_busy;
    assign o_out.out_last = r_cmd.last && w_at_end;
    always_comb begin
        case (r_idx)
            2'd0:    o_out.out_byte = r_cmd.b0;
            2'd1:    o_out.out_byte = r_cmd.b1;
            default: o_out.out_byte = r_cmd.b2;
        endcase
    end

    // Step through the bytes of a command, loading the next one as the
    // final byte is transferred.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_cmd_ready) begin
            r_busy <= i_cmd_valid;
            r_idx  <= 2'd0;
        end else if (w_out_xfer) begin
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_ready && i_cmd_valid) begin
            r_cmd <= i_cmd;
        end
    end

endmodule

/* src/percent_escape_decoder.sv */
`timescale 1ns / 1ps

// Percent-escape decoder. Encoded bytes enter on i_in, one per transfer, with
// in_last on the final byte of each string; decoded bytes leave on o_out with
// out_last on the final decoded byte. "%XY" with two uppercase hex digits
// becomes one byte; a bad escape passes its three bytes through, and a '%'
// among the last two bytes of a string passes through literally. The input
// takes one byte per cycle while the command queue (QUEUE_DEPTH entries) has
// room. The output side emits one byte per cycle while o_out is ready; a plain
// byte gives one output byte, a valid escape takes three input bytes for one
// output byte, and a bad escape gives three output bytes. Each command passes
// through the command queue and the back end's command register.
module percent_escape_decoder #(
    parameter int QUEUE_DEPTH = ped_pkg::QUEUE_DEPTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ped_in_if.sink    i_in,
    ped_out_if.source o_out
);
    import ped_pkg::*;

    logic w_push_valid, w_push_ready;
    logic w_pop_valid, w_pop_ready;
    t_cmd w_push_cmd, w_pop_cmd;

    // Front end: scan and classify input bytes.
    ped_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (w_push_valid),
        .i_cmd_ready (w_push_ready),
        .o_cmd       (w_push_cmd)
    );

    // Command queue between the two ends.
    ped_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_cmd   (w_push_cmd),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_cmd    (w_pop_cmd)
    );

    // Back end: emit the bytes of each command.
    ped_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_pop_valid),
        .o_cmd_ready (w_pop_ready),
        .i_cmd       (w_pop_cmd),
        .o_out       (o_out)
    );

    // A command from the front end is never offered to a full queue.
    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_valid |-> w_push_ready)
        else $error("command produced while queue full");

    // Every command carries one to three bytes.
    a_cmd_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_valid |-> (w_push_cmd.count != 2'd0))
        else $error("empty command pushed");

    // Output is idle in the cycle after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_out.valid)
        else $error("output valid right after reset");

endmodule
